[rtl/core/ilst_pkg.sv]
// Shared types and constants for the indexed list engine.
`default_nettype none

package ilst_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;

   // Fixed field widths of the transaction payloads.
   localparam int TYPE_W   = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CNT_OUT_W = 5;

   // Internal widths follow the list depth.
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   typedef enum logic [TYPE_W-1:0] {
      OP_ADD_FRONT    = 3'd0,
      OP_ADD_BACK     = 3'd1,
      OP_READ         = 3'd2,
      OP_WRITE        = 3'd3,
      OP_REMOVE_FRONT = 3'd4,
      OP_REMOVE_BACK  = 3'd5,
      OP_REMOVE_AT    = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   data_out;
      logic [STATUS_W-1:0]  status;
      logic [CNT_OUT_W-1:0] count;
   } rsp_item_type;

   // Broadcast from the decoder to every cell of the chain.
   typedef struct packed {
      logic                  shift_up;
      logic                  shift_down;
      logic                  write_en;
      logic [CMP_W-1:0]      sel;
      logic [DATA_WIDTH-1:0] value;
   } ctrl_type;

endpackage

`default_nettype wire

[rtl/core/ilst_cell.sv]
// One storage cell of the list chain: holds one entry and a read tap stage.
`default_nettype none

module ilst_cell (
   input  logic                           clock,
   input  logic [ilst_pkg::IDX_W-1:0]      cell_index,
   input  ilst_pkg::ctrl_type              ctrl,
   input  logic [ilst_pkg::DATA_WIDTH-1:0] left_data,
   input  logic [ilst_pkg::DATA_WIDTH-1:0] right_data,
   input  logic [ilst_pkg::DATA_WIDTH-1:0] tap_in,
   output logic [ilst_pkg::DATA_WIDTH-1:0] tap_out,
   output logic [ilst_pkg::DATA_WIDTH-1:0] data
);
   import ilst_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic [CMP_W-1:0]      idx_ext;
   logic                  hit;

   assign idx_ext = CMP_W'(cell_index);
   assign hit     = (idx_ext == ctrl.sel);

   always_comb begin
      if (ctrl.shift_up) begin
         data_in = (cell_index == '0) ? ctrl.value : left_data;
      end else if (ctrl.shift_down && (idx_ext >= ctrl.sel)) begin
         data_in = right_data;
      end else if (ctrl.write_en && hit) begin
         data_in = ctrl.value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Selected cell drops its pre-update word onto the tap line.
   assign tap_out = hit ? data_ff : tap_in;
   assign data    = data_ff;

endmodule

`default_nettype wire

[rtl/core/indexed_list_engine.sv]
// Top level of the indexed list engine: decoder, cell chain and result register.
`default_nettype none

// Ordered list of up to CAPACITY words kept in a chain of cells, position 0 at
// cell 0. One transaction is taken per clock unless the request is stalled: the
// decoder checks the request against the count, every cell compares its own
// position with the selected index in parallel, and the whole chain shifts up
// (add front), shifts down from the index (removes) or writes one cell within
// that same edge. Reads and removes pick the old word off a tap line that runs
// along the chain. Each request produces exactly one result transaction in the
// cycle after it is taken, carrying the word read or removed, a status and the
// count after the request. The result sits in an output register; a new request
// is stalled only while that register is full and its result is itself stalled.
// Out-of-range index or an add to a full list changes nothing. Entries above the
// count are never read, so cell contents need no reset.
module indexed_list_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ilst_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ilst_pkg::rsp_item_type rsp_item
);
   import ilst_pkg::*;

   logic                  req_fire;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic [COUNT_W-1:0]    count_next;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_ff;
   rsp_item_type          rsp_in;
   ctrl_type              ctrl;
   logic                  take_word;
   status_type            status;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      pos_ext;
   logic                  full;

   logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic [DATA_WIDTH-1:0] tap       [CAPACITY+1];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign cnt_ext = CMP_W'(count_ff);
   assign pos_ext = CMP_W'(req_item.position);
   assign full    = (count_ff == COUNT_W'(CAPACITY));

   // Request decode: build the broadcast for the chain.
   always_comb begin
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;
      ctrl.write_en   = 1'b0;
      ctrl.sel        = '0;
      ctrl.value      = req_item.value[DATA_WIDTH-1:0];
      take_word       = 1'b0;
      status          = ST_OK;
      count_next      = count_ff;
      unique case (op_type'(req_item.req_type))
         OP_ADD_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.shift_up = 1'b1;
               count_next    = count_ff + 1'b1;
            end
         end
         OP_ADD_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.write_en = 1'b1;
               ctrl.sel      = cnt_ext;
               count_next    = count_ff + 1'b1;
            end
         end
         OP_READ: begin
            if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               ctrl.sel  = pos_ext;
               take_word = 1'b1;
            end
         end
         OP_WRITE: begin
            if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               ctrl.sel      = pos_ext;
               ctrl.write_en = 1'b1;
            end
         end
         OP_REMOVE_FRONT: begin
            if (count_ff != '0) begin
               ctrl.sel        = '0;
               ctrl.shift_down = 1'b1;
               take_word       = 1'b1;
               count_next      = count_ff - 1'b1;
            end
         end
         OP_REMOVE_BACK: begin
            if (count_ff != '0) begin
               ctrl.sel        = cnt_ext - 1'b1;
               ctrl.shift_down = 1'b1;
               take_word       = 1'b1;
               count_next      = count_ff - 1'b1;
            end
         end
         OP_REMOVE_AT: begin
            // index zero behaves as remove front, including the empty case
            if (pos_ext == '0) begin
               if (count_ff != '0) begin
                  ctrl.shift_down = 1'b1;
                  take_word       = 1'b1;
                  count_next      = count_ff - 1'b1;
               end
            end else if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               ctrl.sel        = pos_ext;
               ctrl.shift_down = 1'b1;
               take_word       = 1'b1;
               count_next      = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      // Chain only moves on an accepted transaction.
      if (!req_fire) begin
         ctrl.shift_up   = 1'b0;
         ctrl.shift_down = 1'b0;
         ctrl.write_en   = 1'b0;
      end
   end

   // Cell chain. Tap line runs from the back cell toward cell 0.
   assign tap[CAPACITY] = '0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      if (k == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[k-1];
      end
      if (k == CAPACITY - 1) begin : g_tail
         assign right_w = cell_data[k];
      end else begin : g_mid_r
         assign right_w = cell_data[k+1];
      end
      ilst_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(k)),
         .ctrl       (ctrl),
         .left_data  (left_w),
         .right_data (right_w),
         .tap_in     (tap[k+1]),
         .tap_out    (tap[k]),
         .data       (cell_data[k])
      );
   end

   assign count_in = req_fire ? count_next : count_ff;

   always_comb begin
      rsp_in.data_out = take_word ? VALUE_W'(tap[0]) : '0;
      rsp_in.status   = STATUS_W'(status);
      rsp_in.count    = CNT_OUT_W'(count_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("list count above capacity");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count moved without a transaction");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_W'(ST_FULL))
      |-> (rsp_ff.count == CNT_OUT_W'(CAPACITY)))
      else $error("full status with list not full");
`endif

endmodule

`default_nettype wire
